// ----- rtl/rbma_pkg.sv -----
// ----------------------------------------------------------------------------
// rbma_pkg
// Shared constants and types for the ring buffer moving average block.
// ----------------------------------------------------------------------------
package rbma_pkg;

  // Default sizing
  localparam int DEFAULT_WINDOW_DEPTH = 64;
  localparam int DEFAULT_SAMPLE_BITS  = 20;

  // Input command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_OUTPUT
  } rbma_state_e;

endpackage

// ----- rtl/rbma_in_if.sv -----
// ----------------------------------------------------------------------------
// rbma_in_if
// Input channel: a command and a signed sample per word, valid/ready.
// ----------------------------------------------------------------------------
interface rbma_in_if #(
  parameter int SAMPLE_BITS = rbma_pkg::DEFAULT_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

// ----- rtl/rbma_out_if.sv -----
// ----------------------------------------------------------------------------
// rbma_out_if
// Result channel: mean, last sample, flags and fill count, valid/ready.
// ----------------------------------------------------------------------------
interface rbma_out_if #(
  parameter int SAMPLE_BITS = rbma_pkg::DEFAULT_SAMPLE_BITS,
  parameter int COUNT_BITS  = $clog2(rbma_pkg::DEFAULT_WINDOW_DEPTH + 1)
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          average_valid;
  logic signed [SAMPLE_BITS-1:0] last_sample;
  logic                          last_valid;
  logic [COUNT_BITS-1:0]         fill_count;

  modport source (output valid, output average, output average_valid,
                  output last_sample, output last_valid, output fill_count,
                  input ready);
  modport sink   (input valid, input average, input average_valid,
                  input last_sample, input last_valid, input fill_count,
                  output ready);
endinterface

// ----- rtl/rbma_ram.sv -----
// ----------------------------------------------------------------------------
// rbma_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rbma_ram #(
  parameter int WIDTH = rbma_pkg::DEFAULT_SAMPLE_BITS,
  parameter int DEPTH = rbma_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rbma_div.sv -----
// ----------------------------------------------------------------------------
// rbma_div
// Restoring divider, one quotient bit per cycle. Divides the magnitude of a
// two's complement dividend by an unsigned nonzero count.
// ----------------------------------------------------------------------------
module rbma_div #(
  parameter int SUM_W = 26,
  parameter int CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  dq_q, dq_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W-1:0]  rem_sub;
  logic              q_bit;

  // Magnitude of the dividend
  assign mag = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  // One restoring step: bring down the next dividend bit, try a subtract.
  // The new remainder is below the divisor, so the low bits suffice.
  assign rem_shift = {rem_q, dq_q[SUM_W-1]};
  assign rem_sub   = rem_shift[CNT_W-1:0] - dsr_q;
  assign q_bit     = (rem_shift >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dq_d   = mag;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dq_d   = {dq_q[SUM_W-2:0], q_bit};
      rem_d  = q_bit ? rem_sub : rem_shift[CNT_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// ----- rtl/ring_buffer_moving_average_top.sv -----
// ----------------------------------------------------------------------------
// ring_buffer_moving_average_top
// Boxcar moving average over the latest WINDOW_DEPTH samples, kept in a ring
// RAM with a running sum, fill count and last sample.
//
// Sequence: an accepted word passes the update and start states; a sample
//   word then waits in the divide state for the bit-serial divider.
// Throughput: one word at a time; a new word is taken only after the output
//   state has loaded the previous result, which waits on a stalled output.
// Reset: sum, count, pointer and last sample clear at once; RAM contents are
//   not cleared, entries are always written before their read data is used.
// ----------------------------------------------------------------------------
module ring_buffer_moving_average_top #(
  parameter int WINDOW_DEPTH = rbma_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = rbma_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rbma_in_if.sink    in_i,
  rbma_out_if.source out_o
);
  import rbma_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);

  rbma_state_e            state_q, state_d;
  logic                   cmd_q, cmd_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [ADDR_W-1:0]      wp_q, wp_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] last_q, last_d;
  logic                   last_valid_q, last_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_avg_q, out_avg_d;
  logic                   out_avg_valid_q, out_avg_valid_d;
  logic [SAMPLE_BITS-1:0] out_last_q, out_last_d;
  logic                   out_last_valid_q, out_last_valid_d;
  logic [CNT_W-1:0]       out_fill_q, out_fill_d;

  logic                   in_accept;
  logic                   full;
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SUM_W-1:0]       new_ext;
  logic [SUM_W-1:0]       old_ext;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quot;
  logic [SUM_W-1:0]       mean_full;
  logic                   out_load;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign full = (count_q == CNT_W'(WINDOW_DEPTH));
  assign out_load = !out_valid_q || out_o.ready;

  // Sign-extended new sample and evicted sample
  assign new_ext = {{(SUM_W - SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
  assign old_ext = full ? {{(SUM_W - SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata}
                        : '0;

  // Signed mean from the quotient magnitude
  assign mean_full = sum_q[SUM_W-1] ? (~div_quot + 1'b1) : div_quot;

  // Ring storage: read the slot at acceptance, write the new sample to it in the next cycle
  rbma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (in_accept),
    .addr_i  (wp_q),
    .wdata_i (sample_q),
    .rdata_o (ram_rdata)
  );

  rbma_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer: next state, window update and output load
  always_comb begin
    state_d          = state_q;
    cmd_d            = cmd_q;
    sample_d         = sample_q;
    wp_d             = wp_q;
    count_d          = count_q;
    sum_d            = sum_q;
    last_d           = last_q;
    last_valid_d     = last_valid_q;
    out_valid_d      = out_valid_q;
    out_avg_d        = out_avg_q;
    out_avg_valid_d  = out_avg_valid_q;
    out_last_d       = out_last_q;
    out_last_valid_d = out_last_valid_q;
    out_fill_d       = out_fill_q;
    ram_we           = 1'b0;
    div_start        = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d    = in_i.cmd;
          sample_d = in_i.sample;
          state_d  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (cmd_q == CMD_CLEAR) begin
          wp_d         = '0;
          count_d      = '0;
          sum_d        = '0;
          last_d       = '0;
          last_valid_d = 1'b0;
        end else begin
          ram_we       = 1'b1;
          last_d       = sample_q;
          last_valid_d = 1'b1;
          sum_d        = sum_q + new_ext - old_ext;
          if (!full) begin
            count_d = count_q + 1'b1;
          end
          wp_d = (wp_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        end
        state_d = ST_START;
      end
      ST_START: begin
        if (count_q != '0) begin
          div_start = 1'b1;
          state_d   = ST_DIVIDE;
        end else begin
          state_d = ST_OUTPUT;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (out_load) begin
          out_valid_d      = 1'b1;
          out_avg_d        = (count_q != '0) ? mean_full[SAMPLE_BITS-1:0] : '0;
          out_avg_valid_d  = (count_q != '0);
          out_last_d       = last_q;
          out_last_valid_d = last_valid_q;
          out_fill_d       = count_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wp_q         <= '0;
      count_q      <= '0;
      sum_q        <= '0;
      last_q       <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      count_q      <= count_d;
      sum_q        <= sum_d;
      last_q       <= last_d;
      last_valid_q <= last_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q            <= cmd_d;
    sample_q         <= sample_d;
    out_avg_q        <= out_avg_d;
    out_avg_valid_q  <= out_avg_valid_d;
    out_last_q       <= out_last_d;
    out_last_valid_q <= out_last_valid_d;
    out_fill_q       <= out_fill_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.average       = out_avg_q;
  assign out_o.average_valid = out_avg_valid_q;
  assign out_o.last_sample   = out_last_q;
  assign out_o.last_valid    = out_last_valid_q;
  assign out_o.fill_count    = out_fill_q;

  // Empty window always has a zero sum
  a_empty_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0))
    else $error("nonzero sum with empty window");

  // Fill count never passes the window depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count above window depth");

  // A stored sample and a valid last sample go together
  a_last_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) == last_valid_q)
    else $error("last sample flag out of step with fill count");

  // Divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVIDE))
    else $error("divider done outside divide state");

endmodule

// ----- bench/ring_buffer_moving_average_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_buffer_moving_average_top_test
// Self-checking bench for the boxcar moving average. Each input word is
// predicted at acceptance, and the result word is compared field by field.
// Coverage: directed extremes, clears and rounding toward zero, then random
// runs of samples that fill and wrap the window. Both sides idle in random
// bursts, and one long output stall backs the block up.
// ----------------------------------------------------------------------------
module ring_buffer_moving_average_top_test;
  import rbma_pkg::*;

  localparam int SAMPLE_W    = DEFAULT_SAMPLE_BITS;
  localparam int DEPTH       = DEFAULT_WINDOW_DEPTH;
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_WORDS  = 150;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 40;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
  } window_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       average_valid;
    logic signed [SAMPLE_W-1:0] last_sample;
    logic                       last_valid;
    logic [COUNT_W-1:0]         fill_count;
  } mean_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rbma_in_if  in_ch ();
  rbma_out_if out_ch ();

  ring_buffer_moving_average_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted window state
  logic signed [SAMPLE_W-1:0] win_ring [DEPTH];
  int                         win_ptr;
  int                         win_count;
  longint                     win_sum;
  logic signed [SAMPLE_W-1:0] newest;
  logic                       newest_ok;

  window_word_t pending_words [$];
  mean_result_t expected_means [$];

  int  total_words;
  int  words_accepted;
  int  results_checked;
  int  clears_taken;
  int  full_results;
  int  fail_count;
  int  cycle_count;
  logic word_taken;

  int send_gap;
  int send_idle_pct;
  int stall_left;
  int hold_left;
  bit hold_done;
  int recv_idle_pct;

  // Apply one word to the predicted window and return the result it causes
  function automatic mean_result_t advance_window(logic cmd,
                                                  logic signed [SAMPLE_W-1:0] smp);
    mean_result_t r;
    longint       mean;
    if (cmd == CMD_CLEAR) begin
      win_ptr   = 0;
      win_count = 0;
      win_sum   = 0;
      newest    = '0;
      newest_ok = 1'b0;
    end else begin
      newest    = smp;
      newest_ok = 1'b1;
      if (win_count < DEPTH) begin
        win_sum += longint'(smp);
        win_count++;
      end else begin
        // full window: oldest sample drops out
        win_sum += longint'(smp) - longint'(win_ring[win_ptr]);
      end
      win_ring[win_ptr] = smp;
      win_ptr = (win_ptr == DEPTH - 1) ? 0 : win_ptr + 1;
    end
    mean = (win_count != 0) ? win_sum / longint'(win_count) : 0;
    r.average       = mean[SAMPLE_W-1:0];
    r.average_valid = (win_count != 0);
    r.last_sample   = newest;
    r.last_valid    = newest_ok;
    r.fill_count    = win_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int style);
    logic signed [SAMPLE_W-1:0] v;
    case (style)
      1: begin
        // mostly near full scale positive, a few negative extremes
        v = ($urandom_range(0, 7) == 0) ? SAMPLE_MIN
                                        : SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 15));
      end
      2: v = SAMPLE_MIN + SAMPLE_W'($urandom_range(0, 15));
      3: begin
        // small values around zero, where truncation shows
        v = SAMPLE_W'(int'($urandom_range(0, 80)) - 40);
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic void queue_word(logic cmd, logic signed [SAMPLE_W-1:0] smp);
    window_word_t w;
    w.cmd    = cmd;
    w.sample = smp;
    pending_words.push_back(w);
  endfunction

  // Stimulus, reset and end of run
  initial begin
    int seq_len;
    int style;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_ADD;
    in_ch.sample  = '0;
    out_ch.ready  = 1'b0;
    rst_ni        = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    newest        = '0;
    newest_ok     = 1'b0;

    // Directed: clear on empty, extremes, truncation toward zero
    queue_word(CMD_CLEAR, SAMPLE_MAX);
    queue_word(CMD_ADD, SAMPLE_MAX);
    queue_word(CMD_ADD, SAMPLE_MIN);
    queue_word(CMD_ADD, SAMPLE_W'(-3));
    queue_word(CMD_ADD, '0);
    queue_word(CMD_CLEAR, SAMPLE_MIN);
    queue_word(CMD_ADD, SAMPLE_W'(-1));
    queue_word(CMD_ADD, '0);
    queue_word(CMD_ADD, SAMPLE_W'(-4));
    queue_word(CMD_ADD, SAMPLE_W'(7));
    queue_word(CMD_ADD, 20'h55555);
    queue_word(CMD_ADD, 20'hAAAAA);
    queue_word(CMD_CLEAR, '0);
    queue_word(CMD_CLEAR, '1);
    queue_word(CMD_ADD, SAMPLE_W'(1));
    queue_word(CMD_ADD, SAMPLE_W'(-2));
    queue_word(CMD_CLEAR, 20'h5A5A5);

    // Random runs of samples, most long enough to wrap the window
    while (pending_words.size() < 1200) begin
      case ($urandom_range(0, 9))
        0, 1:    seq_len = $urandom_range(1, DEPTH);
        2:       seq_len = $urandom_range(150, 300);
        default: seq_len = $urandom_range(DEPTH + 1, 200);
      endcase
      style = $urandom_range(0, 5);
      for (int k = 0; k < seq_len && pending_words.size() < 1200; k++) begin
        if ($urandom_range(0, 99) < 2) begin
          queue_word(CMD_CLEAR, SAMPLE_W'($urandom));
        end else begin
          if ($urandom_range(0, 49) == 0) style = $urandom_range(0, 5);
          queue_word(CMD_ADD, pick_sample(style > 3 ? 0 : style));
        end
      end
      queue_word(CMD_CLEAR, SAMPLE_W'($urandom));
    end
    total_words = pending_words.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (words_accepted == total_words);
    wait (results_checked == total_words);
    repeat (DRAIN) @(posedge clk_i);

    $display("Run covered %0d words (%0d clears), %0d results checked.",
             total_words, clears_taken, results_checked);
    $display("Full-window results: %0d, long output stall applied: %0d.",
             full_results, hold_done);
    if (fail_count == 0 && expected_means.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Word driver: new word or idle at the falling edge
  always @(negedge clk_i) begin
    window_word_t w;
    bit           quiet;
    quiet = (words_accepted + TAIL_WORDS >= total_words) || (hold_left > 0);
    if (rst_ni && (!in_ch.valid || word_taken)) begin
      if ($urandom_range(0, 199) == 0) send_idle_pct = $urandom_range(0, 2) * 15;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
        send_gap = $urandom_range(1, 14) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= w.cmd;
        in_ch.sample <= w.sample;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    bit quiet;
    quiet = (words_accepted + TAIL_WORDS >= total_words);
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) recv_idle_pct = $urandom_range(0, 2) * 15;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && words_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on accepted input words, check accepted result words
  always @(posedge clk_i) begin
    mean_result_t exp_r;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        exp_r = advance_window(in_ch.cmd, in_ch.sample);
        expected_means.push_back(exp_r);
        words_accepted++;
        if (in_ch.cmd == CMD_CLEAR) clears_taken++;
        if (win_count == DEPTH) full_results++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_means.size() == 0) begin
          $error("result word with no expectation pending");
          fail_count++;
        end else begin
          exp_r = expected_means.pop_front();
          results_checked++;
          if (out_ch.average !== exp_r.average) begin
            $error("average: expected %0d, actual %0d", exp_r.average, out_ch.average);
            fail_count++;
          end
          if (out_ch.average_valid !== exp_r.average_valid) begin
            $error("average_valid: expected %0d, actual %0d",
                   exp_r.average_valid, out_ch.average_valid);
            fail_count++;
          end
          if (out_ch.last_sample !== exp_r.last_sample) begin
            $error("last_sample: expected %0d, actual %0d",
                   exp_r.last_sample, out_ch.last_sample);
            fail_count++;
          end
          if (out_ch.last_valid !== exp_r.last_valid) begin
            $error("last_valid: expected %0d, actual %0d",
                   exp_r.last_valid, out_ch.last_valid);
            fail_count++;
          end
          if (out_ch.fill_count !== exp_r.fill_count) begin
            $error("fill_count: expected %0d, actual %0d",
                   exp_r.fill_count, out_ch.fill_count);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d words accepted.",
               cycle_count, words_accepted, total_words);
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
rtl/rbma_pkg.sv
rtl/rbma_in_if.sv
rtl/rbma_out_if.sv
rtl/rbma_ram.sv
rtl/rbma_div.sv
rtl/ring_buffer_moving_average_top.sv
bench/ring_buffer_moving_average_top_test.sv
